// ===== src/wpo_pkg.sv =====
// Shared types and constants for the waveform peak overview block.
// No dependencies; every other file of the block imports this package.
package wpo_pkg;

  localparam int FRAME_BITS     = 24;
  localparam int BIN_NUM_BITS   = 9;
  localparam int MAX_RESULTS    = 64;
  localparam int CNT_BITS       = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEREO_MODE = 2'd1;

  localparam logic [FRAME_BITS-1:0] FRAME_COUNT_RESET = 24'd8;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/waveform_peak_overview_top.sv =====
// Waveform peak overview: takes one frame word per cycle into a four-entry
// queue, unless in_stall is raised while that queue is full. The back part
// closes the bins that end on a frame one at a time, emitted or skipped,
// before it retires that frame; a stalled result word holds it further.
// BIN_COUNT must be a power of two. After reset and after each frame_count
// write the bin bounds are set up in the ST_MUL and ST_ADD states in turn.
// Depends on wpo_pkg, wpo_front, wpo_queue and wpo_back.
module waveform_peak_overview_top import wpo_pkg::*; #(
  parameter int BIN_COUNT   = 512,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [SAMPLE_BITS-1:0]        peak_value,
  output logic [BIN_NUM_BITS-1:0]       bin_number,
  output logic                          last_of_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [FRAME_BITS-1:0]         cfg_data
);

  localparam int ENTRY_BITS = SAMPLE_BITS + FRAME_BITS;

  logic [FRAME_BITS-1:0] frame_count;
  logic                  stereo_mode;
  logic                  cfg_write;
  logic                  recalc;
  logic                  push;
  logic                  pop;
  logic [ENTRY_BITS-1:0] push_data;
  logic [ENTRY_BITS-1:0] head_data;
  q_status_t             q_status;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign recalc    = cfg_write && (cfg_index == REG_FRAME_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
      stereo_mode <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_COUNT) begin
        frame_count <= cfg_data;
      end else if (cfg_index == REG_STEREO_MODE) begin
        stereo_mode <= cfg_data[0];
      end
    end
  end

  wpo_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .stereo_mode  (stereo_mode),
    .frame_count  (frame_count),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  wpo_queue #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (q_status)
  );

  wpo_back #(.BIN_COUNT(BIN_COUNT), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .recalc      (recalc),
    .frame_count (frame_count),
    .head_data   (head_data),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .peak_value  (peak_value),
    .bin_number  (bin_number),
    .last_of_run (last_of_run)
  );

endmodule

// ===== src/wpo_queue.sv =====
// Small register FIFO between the front and back parts.
// Depends on wpo_pkg for the status struct.
module wpo_queue import wpo_pkg::*; #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output q_status_t        status
);

  localparam int PTR_BITS = $clog2(DEPTH);

  logic [WIDTH-1:0]  entries [DEPTH];
  logic [PTR_BITS:0] wr_ptr;
  logic [PTR_BITS:0] rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign status.empty = (wr_ptr == rd_ptr);
  assign status.full  = (wr_ptr[PTR_BITS] != rd_ptr[PTR_BITS]) &&
                        (wr_ptr[PTR_BITS-1:0] == rd_ptr[PTR_BITS-1:0]);
  assign do_push   = push && !status.full;
  assign do_pop    = pop && !status.empty;
  assign head_data = entries[rd_ptr[PTR_BITS-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr[PTR_BITS-1:0]] <= push_data;
    end
  end

endmodule

// ===== src/wpo_front.sv =====
// Front part: takes input words, down-mixes, forms the magnitude and
// drops frames past the end. Depends on wpo_pkg.
module wpo_front import wpo_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                         stereo_mode,
  input  logic [FRAME_BITS-1:0]        frame_count,
  input  q_status_t                    q_status,
  output logic                         push,
  output logic [SAMPLE_BITS+FRAME_BITS-1:0] push_data
);

  logic [FRAME_BITS-1:0]  frame_index;
  logic signed [SAMPLE_BITS:0] left_ext;
  logic signed [SAMPLE_BITS:0] right_ext;
  logic signed [SAMPLE_BITS:0] sum;
  logic [SAMPLE_BITS-1:0] mix;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   accept;

  assign left_ext  = {left_sample[SAMPLE_BITS-1], left_sample};
  assign right_ext = stereo_mode ? {right_sample[SAMPLE_BITS-1], right_sample} : left_ext;
  assign sum       = left_ext + right_ext;
  assign mix       = sum[SAMPLE_BITS:1];
  assign mag       = mix[SAMPLE_BITS-1] ? (~mix + 1'b1) : mix;

  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign push      = accept && (frame_index < frame_count);
  assign push_data = {mag, frame_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index <= '0;
    end else if (push) begin
      frame_index <= frame_index + 1'b1;
    end
  end

endmodule

// ===== src/wpo_back.sv =====
// Back part: walks the bin bounds for each queued frame, keeps the running
// peak and drives the output register. Depends on wpo_pkg.
module wpo_back import wpo_pkg::*; #(
  parameter int BIN_COUNT   = 512,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          recalc,
  input  logic [FRAME_BITS-1:0]         frame_count,
  input  logic [SAMPLE_BITS+FRAME_BITS-1:0] head_data,
  input  q_status_t                     q_status,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [SAMPLE_BITS-1:0]        peak_value,
  output logic [BIN_NUM_BITS-1:0]       bin_number,
  output logic                          last_of_run
);

  localparam int BIN_BITS = $clog2(BIN_COUNT);
  localparam int KW       = BIN_BITS + 1;
  localparam int AW       = KW + FRAME_BITS;
  localparam int EW       = FRAME_BITS + 1;

  localparam logic [1:0] ST_MUL = 2'd0;
  localparam logic [1:0] ST_ADD = 2'd1;
  localparam logic [1:0] ST_RUN = 2'd2;

  logic [1:0]             state;
  logic [KW-1:0]          current_bin;
  logic [AW-1:0]          acc_start;
  logic [AW-1:0]          acc_end;
  logic [AW-1:0]          bin_product;
  logic [SAMPLE_BITS-1:0] running_peak;
  logic                   fresh;
  logic [CNT_BITS-1:0]    count;
  logic                   pend_valid;
  logic [SAMPLE_BITS-1:0] pend_peak;
  logic [KW-1:0]          pend_bin;

  logic [SAMPLE_BITS-1:0] mag;
  logic [FRAME_BITS-1:0]  frame;
  logic [EW-1:0]          frame_ext;
  logic [EW-1:0]          frame_plus;
  logic [EW-1:0]          start_f;
  logic [EW-1:0]          end_f;
  logic [SAMPLE_BITS-1:0] peak_eff;
  logic                   close;
  logic                   emit;
  logic                   out_free;
  logic                   advance;
  logic                   load_out;

  assign mag        = head_data[SAMPLE_BITS+FRAME_BITS-1:FRAME_BITS];
  assign frame      = head_data[FRAME_BITS-1:0];
  assign frame_ext  = {1'b0, frame};
  assign frame_plus = frame_ext + 1'b1;
  assign start_f    = acc_start[AW-1:BIN_BITS];
  assign end_f      = acc_end[AW-1:BIN_BITS];
  assign bin_product = {{FRAME_BITS{1'b0}}, current_bin} * {{KW{1'b0}}, frame_count};

  assign peak_eff = (fresh && (mag > running_peak)) ? mag : running_peak;
  assign close    = !current_bin[KW-1] &&
                    ((end_f == start_f) ? (start_f <= frame_ext) : (end_f <= frame_plus));
  assign emit     = (count < CNT_BITS'(MAX_RESULTS));
  assign out_free = !out_valid || !out_stall;
  assign advance  = (state == ST_RUN) && !q_status.empty && (!pend_valid || out_free);
  assign pop      = advance && !close;
  assign load_out = advance && pend_valid && (!close || emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_MUL;
      current_bin  <= '0;
      running_peak <= '0;
      fresh        <= 1'b1;
      count        <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (recalc) begin
        state <= ST_MUL;
      end else begin
        unique case (state)
          ST_MUL: begin
            state <= ST_ADD;
          end
          ST_ADD: begin
            state <= ST_RUN;
          end
          ST_RUN: begin
            if (advance) begin
              if (close) begin
                fresh        <= 1'b0;
                running_peak <= (end_f <= frame_ext) ? mag : '0;
                current_bin  <= current_bin + 1'b1;
                if (emit) begin
                  count      <= count + 1'b1;
                  pend_valid <= 1'b1;
                end
              end else begin
                fresh        <= 1'b1;
                running_peak <= peak_eff;
                count        <= '0;
                pend_valid   <= 1'b0;
              end
            end
          end
          default: begin
            state <= ST_MUL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      acc_start <= bin_product;
    end else if (state == ST_ADD) begin
      acc_end <= acc_start + {{KW{1'b0}}, frame_count};
    end else if (advance && close) begin
      acc_start <= acc_end;
      acc_end   <= acc_end + {{KW{1'b0}}, frame_count};
    end
    if (advance && close && emit) begin
      pend_peak <= peak_eff;
      pend_bin  <= current_bin;
    end
    if (load_out) begin
      peak_value  <= pend_peak;
      bin_number  <= BIN_NUM_BITS'(pend_bin);
      last_of_run <= !close;
    end
  end

endmodule

// ===== src/wpo_checker.sv =====
// Port-level checks for the waveform peak overview top level.
// Depends on wpo_pkg; bound to waveform_peak_overview_top below.
module wpo_checker import wpo_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [SAMPLE_BITS-1:0]        peak_value,
  input logic [BIN_NUM_BITS-1:0]       bin_number,
  input logic                          last_of_run
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result word dropped");

  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!peak_value[SAMPLE_BITS-1] || (peak_value[SAMPLE_BITS-2:0] == '0)))
    else $error("peak above full-scale magnitude");

  a_bin_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_run) ##1 out_valid |->
      (bin_number == $past(bin_number) + 1'b1))
    else $error("bin index skipped within a run");

endmodule

bind waveform_peak_overview_top wpo_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wpo_checker (.*);
